// ===== design/sblc_pkg.sv =====
// shared types, constants and tables for the spectrum bar level conditioner
`timescale 1ns / 1ps
`default_nettype none
package sblc_pkg;

  localparam int BANDS  = 10;
  localparam int HALF   = BANDS / 2;
  localparam int LVL_W  = 7;
  localparam int IDX_W  = $clog2(BANDS + 1);
  localparam int CI_W   = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int SUM_W  = $clog2(100 * HALF + 1);
  localparam int NUM_W  = 14;
  localparam int DEN_W  = 7;
  localparam int CNT_W  = 2;

  // 2*sum/BANDS as a reciprocal multiply, exact while 2*sum < 2^AVG_K/BANDS
  localparam int AVG_K     = 18;
  localparam int AVG_RCP   = ((1 << AVG_K) + BANDS - 1) / BANDS;
  // avg/3 as a reciprocal multiply, exact for avg below 512
  localparam int THIRD_K   = 9;
  localparam int THIRD_RCP = 171;

  localparam logic [LVL_W-1:0] LVL_MAX   = 7'd100;
  localparam logic [15:0]      LFSR_SEED = 16'hACE1;
  localparam logic [15:0]      LFSR_MASK = 16'hB400;

  localparam logic [LVL_W-1:0] CEIL_TABLE [0:100] = '{
    7'd1,  7'd2,  7'd4,  7'd6,  7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd18,
    7'd20, 7'd22, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32, 7'd34, 7'd36, 7'd38,
    7'd40, 7'd42, 7'd44, 7'd46, 7'd48, 7'd50, 7'd52, 7'd54, 7'd56, 7'd58,
    7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69,
    7'd70, 7'd70, 7'd71, 7'd71, 7'd72, 7'd72, 7'd73, 7'd73, 7'd74, 7'd74,
    7'd75, 7'd75, 7'd76, 7'd76, 7'd77, 7'd77, 7'd78, 7'd78, 7'd79, 7'd79,
    7'd80, 7'd80, 7'd81, 7'd81, 7'd82, 7'd82, 7'd83, 7'd83, 7'd84, 7'd84,
    7'd85, 7'd85, 7'd86, 7'd86, 7'd87, 7'd87, 7'd88, 7'd88, 7'd89, 7'd89,
    7'd90, 7'd90, 7'd91, 7'd91, 7'd92, 7'd92, 7'd93, 7'd93, 7'd94, 7'd94,
    7'd95, 7'd95, 7'd96, 7'd96, 7'd97, 7'd97, 7'd98, 7'd98, 7'd99, 7'd100,
    7'd100
  };

  // per-band stored state that rotates along the ring
  typedef struct packed {
    logic [LVL_W-1:0] sv;
    logic [LVL_W-1:0] pv;
    logic [CNT_W-1:0] sc;
  } cell_t;

  // ranking token carried around the ring
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [CI_W-1:0]  idx;
    logic [CI_W-1:0]  rank;
  } tok_t;

  typedef struct packed {
    logic load;
    logic tok_init;
    logic tok_shift;
    logic tok_count;
    logic ring_shift;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== design/sblc_cell.sv =====
// one band cell: stored level, history and a ranking token
`timescale 1ns / 1ps
`default_nettype none
module sblc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sblc_pkg::ctrl_t             ctrl,
  input  wire logic                        sel,
  input  wire logic [sblc_pkg::LVL_W-1:0]  lvl_in,
  input  wire logic [sblc_pkg::CI_W-1:0]   my_idx,
  input  wire sblc_pkg::cell_t             nb_cell,
  input  wire sblc_pkg::tok_t              nb_tok,
  output sblc_pkg::cell_t                  slot,
  output sblc_pkg::tok_t                   tok
);
  import sblc_pkg::*;

  logic below;

  // the neighbor's token outranks this cell's level
  assign below = (slot.sv < nb_tok.lvl) ||
                 ((slot.sv == nb_tok.lvl) && (my_idx < nb_tok.idx));

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      slot.sv <= lvl_in;
    end else if (ctrl.ring_shift) begin
      slot.sv <= nb_cell.sv;
    end
    if (rst) begin
      slot.pv <= '0;
      slot.sc <= '0;
    end else if (ctrl.ring_shift) begin
      slot.pv <= nb_cell.pv;
      slot.sc <= nb_cell.sc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tok_init) begin
      tok.lvl  <= slot.sv;
      tok.idx  <= my_idx;
      tok.rank <= '0;
    end else if (ctrl.tok_shift) begin
      tok.lvl  <= nb_tok.lvl;
      tok.idx  <= nb_tok.idx;
      tok.rank <= (ctrl.tok_count && below) ? nb_tok.rank + 1'b1 : nb_tok.rank;
    end
  end

endmodule
`default_nettype wire

// ===== design/sblc_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sblc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [sblc_pkg::NUM_W-1:0]  num,
  input  wire logic [sblc_pkg::DEN_W-1:0]  den,
  output logic                             busy,
  output logic                             done,
  output logic [sblc_pkg::NUM_W-1:0]       quo
);
  import sblc_pkg::*;

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dreg;
  logic [ITER_W-1:0] iter;
  logic [DEN_W:0]    sh;
  logic              fits;

  assign sh   = {rem, quo[NUM_W-1]};
  assign fits = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(NUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(sh - {1'b0, dreg}) : sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== design/spectrum_bar_level_conditioner_top.sv =====
// top level: band loading, ring of band cells and per-frame remap sequencer
//
// Input channel: in_valid/in_stall carry band_db (signed dB) and last_band.
// Each band is taken while the block is idle and stored in the cell picked
// by the load count; extra bands beyond BANDS are dropped.
// A request with last_band set starts the frame pass and raises in_stall
// until every result of the frame has been taken.
// The pass ranks the stored levels by circulating tokens round the ring,
// sums the smaller half and finds the maximum, then derives avgMin and its
// third by reciprocal multiplies.
// Each band then takes a remap (a divider run only when avgMin < max and the
// level is not below avgMin), a still check, a noise step and the result hold.
// Output channel: out_valid/out_stall carry bar_level and last_level, one
// request per band in band order; last_level marks the final band.
// While out_stall is high the result is held unchanged and the ring waits.
// Reset (rst, synchronous) clears the load count, the history and still
// counts, loads the noise LFSR seed and returns the block to idle.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_bar_level_conditioner_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [7:0]          band_db,
  input  wire logic                       last_band,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [sblc_pkg::LVL_W-1:0]      bar_level,
  output logic                            last_level
);
  import sblc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RINIT, S_RANK, S_SUM, S_AVG, S_MIN,
    S_BAND, S_DWAIT, S_STILL, S_MOD, S_EMIT, S_OUT
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  load_index;
  logic [CI_W-1:0]   cnt;
  logic [LVL_W-1:0]  maxv, avg, nmin, nmax, rb;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  sc_new;
  logic              noise;
  logic [2:0]        nmod;
  logic [15:0]       lfsr;

  ctrl_t             ctrl;
  cell_t             cells [BANDS];
  tok_t              toks  [BANDS];
  cell_t             tail;
  logic              in_acc, out_acc;

  // input level conversion
  logic signed [7:0] dsat;
  logic [LVL_W-1:0]  vraw, lvl_in;
  logic [14:0]       vprod;

  // frame statistics
  logic [31:0]       aprod;
  logic [15:0]       nprod;

  // divider
  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;

  // per band
  logic [LVL_W-1:0]  head, pdiff;
  logic [13:0]       rprod;
  logic [7:0]        rsum;
  logic [15:0]       lfsr_step;
  logic [31:0]       mprod;
  logic [15:0]       mq;
  logic [15:0]       mrem;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    if (band_db < -8'sd90) begin
      dsat = -8'sd90;
    end else if (band_db > 8'sd0) begin
      dsat = 8'sd0;
    end else begin
      dsat = band_db;
    end
  end
  assign vraw   = LVL_W'(dsat + 8'sd90);
  // v/10 as a reciprocal multiply, exact for v below 1029
  assign vprod  = 15'(vraw) * 15'd205;
  assign lvl_in = vraw + LVL_W'(vprod[14:11]) + 1'b1;

  always_comb begin
    ctrl = '0;
    ctrl.load       = in_acc && (load_index < IDX_W'(BANDS));
    ctrl.tok_init   = (state == S_RINIT);
    ctrl.tok_shift  = (state == S_RANK) || (state == S_SUM);
    ctrl.tok_count  = (state == S_RANK);
    ctrl.ring_shift = (state == S_OUT) && out_acc;
  end

  assign tail = '{sv: cells[0].sv, pv: bar_level, sc: sc_new};

  genvar gi;
  generate
    for (gi = 0; gi < BANDS; gi++) begin : g_cell
      cell_t nbc;
      tok_t  nbt;
      if (gi == BANDS - 1) begin : g_end
        assign nbc = tail;
        assign nbt = toks[0];
      end else begin : g_mid
        assign nbc = cells[gi+1];
        assign nbt = toks[gi+1];
      end
      sblc_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .sel     (load_index == IDX_W'(gi)),
        .lvl_in  (lvl_in),
        .my_idx  (CI_W'(gi)),
        .nb_cell (nbc),
        .nb_tok  (nbt),
        .slot    (cells[gi]),
        .tok     (toks[gi])
      );
    end
  endgenerate

  // avgMin = 2*sum/BANDS and newMin = avgMin/3
  assign aprod = 32'({sum, 1'b0}) * 32'(AVG_RCP);
  assign nprod = 16'(avg) * 16'(THIRD_RCP);

  assign head  = cells[0].sv;
  assign rprod = 14'(head - avg) * 14'(nmax - nmin);
  assign rsum  = div_quo[7:0] + 8'(nmin);
  assign pdiff = (cells[0].pv > rb) ? cells[0].pv - rb : rb - cells[0].pv;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
  // lfsr mod 5 by reciprocal multiply, exact for 16-bit values
  assign mprod = 32'(lfsr) * 32'h0000CCCD;
  assign mq    = 16'(mprod[31:18]);
  assign mrem  = lfsr - 16'(mq * 16'd5);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_BAND: begin
        div_start = (avg < maxv) && (head >= avg);
        div_num   = rprod;
        div_den   = maxv - avg;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  sblc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_index <= '0;
      cnt        <= '0;
      lfsr       <= LFSR_SEED;
      out_valid  <= 1'b0;
      noise      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (load_index < IDX_W'(BANDS)) begin
              load_index <= load_index + 1'b1;
            end
            if (last_band) begin
              state <= S_RINIT;
            end
          end
        end
        S_RINIT: begin
          cnt   <= '0;
          state <= S_RANK;
        end
        S_RANK: begin
          cnt <= cnt + 1'b1;
          if (cnt == CI_W'(BANDS - 1)) begin
            cnt   <= '0;
            sum   <= '0;
            maxv  <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // token at the head belongs to band cnt, rank fully counted
          if (toks[0].rank < CI_W'(HALF)) begin
            sum <= sum + SUM_W'(toks[0].lvl);
          end
          if (toks[0].lvl > maxv) begin
            maxv <= toks[0].lvl;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CI_W'(BANDS - 1)) begin
            cnt   <= '0;
            state <= S_AVG;
          end
        end
        S_AVG: begin
          avg   <= aprod[AVG_K +: LVL_W];
          state <= S_MIN;
        end
        S_MIN: begin
          nmin  <= nprod[THIRD_K +: LVL_W];
          nmax  <= CEIL_TABLE[maxv];
          state <= S_BAND;
        end
        S_BAND: begin
          if (avg >= maxv) begin
            rb    <= head;
            state <= S_STILL;
          end else if (head < avg) begin
            rb    <= head >> 1;
            state <= S_STILL;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            rb    <= (rsum > 8'(LVL_MAX)) ? LVL_MAX : rsum[LVL_W-1:0];
            state <= S_STILL;
          end
        end
        S_STILL: begin
          noise <= 1'b0;
          if (pdiff < LVL_W'(3)) begin
            if (cells[0].sc == CNT_W'(2)) begin
              sc_new <= '0;
              if (rb >= LVL_W'(5)) begin
                lfsr  <= lfsr_step;
                noise <= 1'b1;
              end
            end else begin
              sc_new <= cells[0].sc + 1'b1;
            end
          end else begin
            sc_new <= '0;
          end
          state <= S_MOD;
        end
        S_MOD: begin
          nmod  <= mrem[2:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          bar_level  <= noise ? rb - LVL_W'(nmod) : rb;
          last_level <= (cnt == CI_W'(BANDS - 1));
          out_valid  <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            cnt       <= cnt + 1'b1;
            if (cnt == CI_W'(BANDS - 1)) begin
              cnt        <= '0;
              load_index <= '0;
              state      <= S_IDLE;
            end else begin
              state <= S_BAND;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no band is taken while a result is on offer
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken during emit");

  // the final result of a frame leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_level && !out_stall) |=> (!out_valid && !in_stall))
    else $error("block not idle after final band");

  // the shared divider is never restarted while running
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire
